@@ rtl/core/btlpm_pkg.sv @@
// Shared types and constants of the binary trie longest prefix match unit.
package btlpm_pkg;

	localparam int HOP_W   = 32;
	localparam int PORT_W  = 4;
	localparam int DEPTH_W = 6;

	localparam logic [DEPTH_W-1:0] MAX_DEPTH = 6'd32;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_CHECK,
		ST_ALLOC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic check;
		logic alloc;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic lookup;
		logic go;
		logic full;
		logic need_zero;
		logic last_alloc;
	} dp_stat_t;

endpackage

@@ rtl/core/btlpm_req_if.sv @@
// Request channel: insert or lookup transaction.
interface btlpm_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [31:0] addr;
	logic [31:0] mask;
	logic [31:0] hop_in;
	logic [3:0]  port;

	modport source(output valid, func, addr, mask, hop_in, port, input ready);
	modport sink(input valid, func, addr, mask, hop_in, port, output ready);
endinterface

@@ rtl/core/btlpm_rsp_if.sv @@
// Response channel: lookup or insert result transaction.
interface btlpm_rsp_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [31:0] hop_out;
	logic [3:0]  port_out;
	logic        status;

	modport source(output valid, found, hop_out, port_out, status, input ready);
	modport sink(input valid, found, hop_out, port_out, status, output ready);
endinterface

@@ rtl/core/btlpm_dpath.sv @@
// Datapath: node memory, root node registers, walk and allocation logic, result register.
module btlpm_dpath #(
	parameter int NODES = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  btlpm_pkg::dp_cmd_t cmd,
	output btlpm_pkg::dp_stat_t stat,
	input  logic               func,
	input  logic [31:0]        addr,
	input  logic [31:0]        mask,
	input  logic [31:0]        hop_in,
	input  logic [3:0]         port,
	output logic               found,
	output logic [31:0]        hop_out,
	output logic [3:0]         port_out,
	output logic               status
);
	import btlpm_pkg::*;

	localparam int IDX_W = $clog2(NODES);
	localparam int CNT_W = $clog2(NODES + 1);
	localparam int NW    = 2 * IDX_W + 1 + HOP_W + PORT_W;
	localparam logic [CNT_W:0] POOL = (CNT_W + 1)'(NODES);

	function automatic logic [DEPTH_W-1:0] ones_in(input logic [31:0] v);
		logic [DEPTH_W-1:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			n = n + DEPTH_W'(v[4*i]) + DEPTH_W'(v[4*i+1])
				+ DEPTH_W'(v[4*i+2]) + DEPTH_W'(v[4*i+3]);
		end
		return n;
	endfunction

	logic [NW-1:0] node_mem [NODES];
	logic [NW-1:0] rdata_q;

	logic               func_q;
	logic [31:0]        path_q;
	logic [DEPTH_W-1:0] len_q;
	logic [HOP_W-1:0]   hop_q;
	logic [PORT_W-1:0]  port_q;
	logic [DEPTH_W-1:0] d_q;
	logic [IDX_W-1:0]   cur_q;
	logic               cur_is_root_q;
	logic [CNT_W-1:0]   nodes_used_q;
	logic               full_q;

	logic [IDX_W-1:0]   root_c0_q;
	logic [IDX_W-1:0]   root_c1_q;
	logic               root_has_q;
	logic [HOP_W-1:0]   root_hop_q;
	logic [PORT_W-1:0]  root_port_q;

	logic               best_has_q;
	logic [HOP_W-1:0]   best_hop_q;
	logic [PORT_W-1:0]  best_port_q;

	logic               found_q;
	logic [HOP_W-1:0]   hop_out_q;
	logic [PORT_W-1:0]  port_out_q;
	logic               status_q;

	logic [IDX_W-1:0]   v_c0, v_c1, child, fresh;
	logic               v_has;
	logic [HOP_W-1:0]   v_hop;
	logic [PORT_W-1:0]  v_port;
	logic [DEPTH_W-1:0] limit, need;
	logic               lookup, go, full, need_zero, last_alloc;
	logic [IDX_W-1:0]   w_c0, w_c1;
	logic               w_has;
	logic [HOP_W-1:0]   w_hop;
	logic [PORT_W-1:0]  w_port;
	logic               mem_we, root_we, rd_en;
	logic [IDX_W-1:0]   waddr;

	// current node, from the root registers or the last memory read
	assign v_c1   = cur_is_root_q ? root_c1_q : rdata_q[NW-1 -: IDX_W];
	assign v_c0   = cur_is_root_q ? root_c0_q : rdata_q[NW-IDX_W-1 -: IDX_W];
	assign v_has  = cur_is_root_q ? root_has_q : rdata_q[HOP_W+PORT_W];
	assign v_hop  = cur_is_root_q ? root_hop_q : rdata_q[PORT_W +: HOP_W];
	assign v_port = cur_is_root_q ? root_port_q : rdata_q[PORT_W-1:0];

	assign lookup     = (func_q == FUNC_LOOKUP);
	assign child      = path_q[31] ? v_c1 : v_c0;
	assign limit      = lookup ? MAX_DEPTH : len_q;
	assign go         = (d_q < limit) && (child != '0);
	assign need       = len_q - d_q;
	assign need_zero  = (len_q == d_q);
	assign full       = ({1'b0, nodes_used_q} + (CNT_W + 1)'(need)) > POOL;
	assign last_alloc = ((d_q + DEPTH_W'(1)) == len_q);
	assign fresh      = nodes_used_q[IDX_W-1:0];

	assign stat = '{lookup: lookup, go: go, full: full, need_zero: need_zero,
		last_alloc: last_alloc};

	always_comb begin
		w_c0   = '0;
		w_c1   = '0;
		w_has  = 1'b0;
		w_hop  = '0;
		w_port = '0;
		if (cmd.alloc) begin
			if (last_alloc) begin
				w_has  = 1'b1;
				w_hop  = hop_q;
				w_port = port_q;
			end else if (path_q[30]) begin
				w_c1 = fresh + IDX_W'(1);
			end else begin
				w_c0 = fresh + IDX_W'(1);
			end
		end else begin
			w_c0   = v_c0;
			w_c1   = v_c1;
			w_has  = v_has;
			w_hop  = v_hop;
			w_port = v_port;
			if (need_zero) begin
				w_has  = 1'b1;
				w_hop  = hop_q;
				w_port = port_q;
			end else if (path_q[31]) begin
				w_c1 = fresh;
			end else begin
				w_c0 = fresh;
			end
		end
	end

	assign root_we = cmd.check && !full && cur_is_root_q;
	assign mem_we  = (cmd.check && !full && !cur_is_root_q) || cmd.alloc;
	assign waddr   = cmd.alloc ? fresh : cur_q;
	assign rd_en   = cmd.step && go;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			node_mem[waddr] <= {w_c1, w_c0, w_has, w_hop, w_port};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= node_mem[child];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_c0_q  <= '0;
			root_c1_q  <= '0;
			root_has_q <= 1'b0;
		end else if (root_we) begin
			root_c0_q  <= w_c0;
			root_c1_q  <= w_c1;
			root_has_q <= w_has;
		end
	end

	always_ff @(posedge clk) begin
		if (root_we) begin
			root_hop_q  <= w_hop;
			root_port_q <= w_port;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q           <= '0;
			cur_is_root_q <= 1'b1;
			nodes_used_q  <= CNT_W'(1);
			full_q        <= 1'b0;
			best_has_q    <= 1'b0;
		end else begin
			if (cmd.load) begin
				d_q           <= '0;
				cur_is_root_q <= 1'b1;
				full_q        <= 1'b0;
				best_has_q    <= 1'b0;
			end
			if (cmd.step) begin
				if (v_has) begin
					best_has_q <= 1'b1;
				end
				if (go) begin
					d_q           <= d_q + DEPTH_W'(1);
					cur_is_root_q <= 1'b0;
				end
			end
			if (cmd.check) begin
				full_q <= full;
			end
			if (cmd.alloc) begin
				d_q          <= d_q + DEPTH_W'(1);
				nodes_used_q <= nodes_used_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			path_q <= addr;
			len_q  <= ones_in(mask);
			hop_q  <= hop_in;
			port_q <= port;
			cur_q  <= '0;
		end
		if (cmd.step) begin
			if (v_has) begin
				best_hop_q  <= v_hop;
				best_port_q <= v_port;
			end
			if (go) begin
				cur_q  <= child;
				path_q <= {path_q[30:0], 1'b0};
			end
		end
		if (cmd.alloc) begin
			path_q <= {path_q[30:0], 1'b0};
		end
		if (cmd.finish) begin
			found_q    <= lookup && best_has_q;
			hop_out_q  <= (lookup && best_has_q) ? best_hop_q : '0;
			port_out_q <= (lookup && best_has_q) ? best_port_q : '0;
			status_q   <= (!lookup && full_q) ? STATUS_FULL : STATUS_OK;
		end
	end

	assign found    = found_q;
	assign hop_out  = hop_out_q;
	assign port_out = port_out_q;
	assign status   = status_q;

endmodule

@@ rtl/core/btlpm_ctrl.sv @@
// Controller: sequences walk, pool check, node allocation and result hand-off.
module btlpm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output btlpm_pkg::dp_cmd_t  cmd,
	input  btlpm_pkg::dp_stat_t stat
);
	import btlpm_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_WALK;
			end
			ST_WALK: begin
				if (!stat.go) state_d = stat.lookup ? ST_DONE : ST_CHECK;
			end
			ST_CHECK: begin
				state_d = (stat.full || stat.need_zero) ? ST_DONE : ST_ALLOC;
			end
			ST_ALLOC: begin
				if (stat.last_alloc) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_WALK:  cmd.step  = 1'b1;
			ST_CHECK: cmd.check = 1'b1;
			ST_ALLOC: cmd.alloc = 1'b1;
			ST_DONE:  cmd.finish = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/core/binary_trie_longest_prefix_match_unit.sv @@
// Top level of the binary trie longest prefix match unit for IPv4 routes.
//
//  channel  dir  contents
//  req      in   func, addr, mask, hop_in, port
//  rsp      out  found, hop_out, port_out, status
//
// One transaction at a time; each trie level is a registered node read.
// Lookup: accept, walk over the levels visited (at most 33), then the result.
// Insert: accept, walk over the levels visited, pool check, one allocation per new node,
// then the result; levels visited plus new nodes never exceed 33.
// Reset leaves an empty table with only the root node; no clearing pass is needed.
// A finished result waits in the output register; req is taken again meanwhile.
module binary_trie_longest_prefix_match_unit #(
	parameter int NODES = 4096
) (
	input logic          clk,
	input logic          arst_n,
	btlpm_req_if.sink    req,
	btlpm_rsp_if.source  rsp
);
	import btlpm_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	btlpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	btlpm_dpath #(
		.NODES (NODES)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.func     (req.func),
		.addr     (req.addr),
		.mask     (req.mask),
		.hop_in   (req.hop_in),
		.port     (req.port),
		.found    (rsp.found),
		.hop_out  (rsp.hop_out),
		.port_out (rsp.port_out),
		.status   (rsp.status)
	);

	ap_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while a transaction is in progress");

	ap_single_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command at once");

	ap_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!rsp.valid || rsp.ready))
		else $error("pending result overwritten");

	ap_full_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status |-> !rsp.found)
		else $error("pool full reported with a match");

endmodule

@@ dv/binary_trie_longest_prefix_match_unit_tb.sv @@
// Self-checking testbench: trie predictor, directed and random routes, random flow control.
module binary_trie_longest_prefix_match_unit_tb;
	import btlpm_pkg::*;

	localparam int NODES = 4096;
	localparam int IDX_W = $clog2(NODES);
	localparam int MAX_GAP = 8;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 80;

	typedef struct {
		logic              func;
		logic [31:0]       addr;
		logic [31:0]       mask;
		logic [HOP_W-1:0]  hop_in;
		logic [PORT_W-1:0] port;
	} route_req_t;

	typedef struct {
		logic              found;
		logic [HOP_W-1:0]  hop;
		logic [PORT_W-1:0] port;
		logic              status;
	} route_rsp_t;

	class route_scoreboard;
		logic [IDX_W-1:0]  child0 [NODES];
		logic [IDX_W-1:0]  child1 [NODES];
		bit                has_route [NODES];
		logic [HOP_W-1:0]  hop_tbl [NODES];
		logic [PORT_W-1:0] port_tbl [NODES];
		int                used;
		route_rsp_t        due [$];
		int                fail_count;

		function new();
			clear_node(0);
			used = 1;
			fail_count = 0;
		endfunction

		function void clear_node(int n);
			child0[n] = '0;
			child1[n] = '0;
			has_route[n] = 1'b0;
			hop_tbl[n] = '0;
			port_tbl[n] = '0;
		endfunction

		function route_rsp_t trie_result(route_req_t r);
			route_rsp_t res;
			int len;
			int depth;
			int cur;
			int nxt;
			int fresh;
			res = '{default: '0};
			cur = 0;
			if (r.func == FUNC_INSERT) begin
				len = $countones(r.mask);
				depth = 0;
				while (depth < len) begin
					nxt = r.addr[31-depth] ? int'(child1[cur]) : int'(child0[cur]);
					if (nxt == 0)
						break;
					cur = nxt;
					depth++;
				end
				if (len - depth > NODES - used) begin
					res.status = STATUS_FULL;
				end else begin
					while (depth < len) begin
						fresh = used;
						used++;
						clear_node(fresh);
						if (r.addr[31-depth])
							child1[cur] = IDX_W'(fresh);
						else
							child0[cur] = IDX_W'(fresh);
						cur = fresh;
						depth++;
					end
					has_route[cur] = 1'b1;
					hop_tbl[cur] = r.hop_in;
					port_tbl[cur] = r.port;
					res.status = STATUS_OK;
				end
			end else begin
				for (depth = 0; depth <= MAX_DEPTH; depth++) begin
					if (has_route[cur]) begin
						res.found = 1'b1;
						res.hop = hop_tbl[cur];
						res.port = port_tbl[cur];
					end
					if (depth == MAX_DEPTH)
						break;
					nxt = r.addr[31-depth] ? int'(child1[cur]) : int'(child0[cur]);
					if (nxt == 0)
						break;
					cur = nxt;
				end
			end
			return res;
		endfunction

		function void note(route_req_t r);
			due.push_back(trie_result(r));
		endfunction

		function void check(route_rsp_t got);
			route_rsp_t want;
			if (due.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: found=%0b hop=%h port=%0d status=%0b",
						got.found, got.hop, got.port, got.status);
				return;
			end
			want = due.pop_front();
			if (got.found !== want.found || got.hop !== want.hop ||
					got.port !== want.port || got.status !== want.status) begin
				fail_count++;
				if (fail_count <= 10)
					$display({"mismatch: expected found=%0b hop=%h port=%0d status=%0b,",
						" got found=%0b hop=%h port=%0d status=%0b"},
						want.found, want.hop, want.port, want.status,
						got.found, got.hop, got.port, got.status);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic hold;
	int   idle_pct;
	int   stall_pct;

	logic [31:0] bases [16];
	route_req_t  known_routes [$];

	route_scoreboard sb = new();

	btlpm_req_if req_ch();
	btlpm_rsp_if rsp_ch();

	binary_trie_longest_prefix_match_unit #(
		.NODES(NODES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic route_req_t mk_route(logic func, logic [31:0] addr, logic [31:0] mask,
			logic [31:0] hop, logic [3:0] port);
		route_req_t r;
		r.func = func;
		r.addr = addr;
		r.mask = mask;
		r.hop_in = hop;
		r.port = port;
		return r;
	endfunction

	function automatic route_req_t random_route(bit fill);
		route_req_t r;
		int roll;
		int len;
		int pick;
		logic [31:0] spread;
		logic [31:0] base;
		r = mk_route($urandom_range(99) < 50 ? FUNC_LOOKUP : FUNC_INSERT,
			$urandom, $urandom, $urandom, 4'($urandom_range(15)));
		roll = $urandom_range(99);
		spread = 32'hffff_ffff >> $urandom_range(8, 32);
		base = bases[$urandom_range(15)];
		pick = known_routes.size() > 0 ? $urandom_range(known_routes.size() - 1) : 0;
		if (r.func == FUNC_LOOKUP) begin
			if (roll < 60)
				r.addr = (base & ~spread) | (r.addr & spread);
			else if (roll < 80 && known_routes.size() > 0)
				r.addr = known_routes[pick].addr;
		end else begin
			if (fill && roll < 85) begin
				r.mask = 32'hffff_ffff;
			end else if (roll < 10) begin
				// noise: random address, arbitrary mask
			end else if (roll < 25 && known_routes.size() > 0) begin
				r.addr = known_routes[pick].addr;
				r.mask = known_routes[pick].mask;
			end else begin
				len = ($urandom_range(3) == 0) ? 32 : $urandom_range(1, 31);
				r.addr = (base & ~spread) | (r.addr & spread);
				r.mask = 32'hffff_ffff << (32 - len);
			end
			if (known_routes.size() < 256)
				known_routes.push_back(r);
		end
		return r;
	endfunction

	task automatic send_route(route_req_t r);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= r.func;
		req_ch.addr <= r.addr;
		req_ch.mask <= r.mask;
		req_ch.hop_in <= r.hop_in;
		req_ch.port <= r.port;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sb.note(r);
	endtask

	task automatic hold_rsp(int cycles);
		hold <= 1'b1;
		repeat (cycles) @(posedge clk);
		hold <= 1'b0;
	endtask

	task automatic run_phase(int count, int idle, int stall, bit fill);
		idle_pct = idle;
		stall_pct <= stall;
		repeat (count) send_route(random_route(fill));
	endtask

	initial begin
		route_rsp_t got;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				got.found = rsp_ch.found;
				got.hop = rsp_ch.hop_out;
				got.port = rsp_ch.port_out;
				got.status = rsp_ch.status;
				sb.check(got);
			end
			rsp_ch.ready <= !hold && ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		#10_000_000;
		$display("** binary_trie_longest_prefix_match_unit: FAILED **");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		hold <= 1'b0;
		stall_pct <= 0;
		idle_pct = 0;
		req_ch.valid <= 1'b0;
		req_ch.func <= FUNC_INSERT;
		req_ch.addr <= '0;
		req_ch.mask <= '0;
		req_ch.hop_in <= '0;
		req_ch.port <= '0;
		foreach (bases[i])
			bases[i] = $urandom;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, /32 and /31 at the top, /32 at zero, non-contiguous mask, overwrite
		send_route(mk_route(FUNC_LOOKUP, 32'h0000_0000, 32'h0, 32'h0, 4'd0));
		send_route(mk_route(FUNC_LOOKUP, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 4'd15));
		send_route(mk_route(FUNC_INSERT, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000, 4'd0));
		send_route(mk_route(FUNC_LOOKUP, 32'hffff_ffff, 32'h0, 32'h0, 4'd0));
		send_route(mk_route(FUNC_LOOKUP, 32'hffff_fffe, 32'h0, 32'h0, 4'd0));
		send_route(mk_route(FUNC_INSERT, 32'hffff_fffe, 32'hffff_fffe, 32'hffff_ffff, 4'd15));
		send_route(mk_route(FUNC_LOOKUP, 32'hffff_fffe, 32'h0, 32'h0, 4'd0));
		send_route(mk_route(FUNC_LOOKUP, 32'hffff_ffff, 32'h0, 32'h0, 4'd0));
		send_route(mk_route(FUNC_INSERT, 32'h0000_0000, 32'hffff_ffff, 32'h5a5a_5a5a, 4'd10));
		send_route(mk_route(FUNC_LOOKUP, 32'h0000_0000, 32'h0, 32'h0, 4'd0));
		send_route(mk_route(FUNC_LOOKUP, 32'h0000_0001, 32'h0, 32'h0, 4'd0));
		send_route(mk_route(FUNC_INSERT, 32'hc0a8_0123, 32'h0f0f_0f00, 32'h0a00_0001, 4'd3));
		send_route(mk_route(FUNC_LOOKUP, 32'hc0af_ffff, 32'h0, 32'h0, 4'd0));
		send_route(mk_route(FUNC_INSERT, 32'hc0a0_0000, 32'hfff0_0000, 32'h0a00_0002, 4'd12));
		send_route(mk_route(FUNC_LOOKUP, 32'hc0a1_2345, 32'h0, 32'h0, 4'd0));
		send_route(mk_route(FUNC_INSERT, 32'h8000_0000, 32'h8000_0000, 32'h0101_0101, 4'd1));
		send_route(mk_route(FUNC_LOOKUP, 32'hc0a1_2345, 32'h0, 32'h0, 4'd0));
		send_route(mk_route(FUNC_LOOKUP, 32'h8000_0000, 32'h0, 32'h0, 4'd0));

		fork
			hold_rsp(HOLD_CYCLES);
		join_none
		run_phase(250, 0, 0, 1'b0);
		run_phase(250, 67, 0, 1'b0);
		run_phase(250, 0, 67, 1'b0);
		run_phase(250, 38, 38, 1'b0);
		run_phase(250, 0, 0, 1'b1);

		// pool likely full: overwrite, refused insert, default route
		send_route(mk_route(FUNC_INSERT, 32'hffff_ffff, 32'hffff_ffff, 32'h1234_5678, 4'd7));
		send_route(mk_route(FUNC_LOOKUP, 32'hffff_ffff, 32'h0, 32'h0, 4'd0));
		send_route(mk_route(FUNC_INSERT, $urandom, 32'hffff_ffff, 32'h0bad_0bad, 4'd6));
		send_route(mk_route(FUNC_INSERT, 32'hffff_ffff, 32'h0000_0000, 32'hdead_beef, 4'd9));
		send_route(mk_route(FUNC_LOOKUP, 32'h1234_5678, 32'h0, 32'h0, 4'd0));
		send_route(mk_route(FUNC_LOOKUP, 32'h0000_0000, 32'h0, 32'h0, 4'd0));
		req_ch.valid <= 1'b0;

		while (sb.due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.fail_count == 0 && sb.due.size() == 0)
			$display("** binary_trie_longest_prefix_match_unit: PASSED **");
		else
			$display("** binary_trie_longest_prefix_match_unit: FAILED **");
		$finish;
	end
endmodule

@@ files.f @@
rtl/core/btlpm_pkg.sv
rtl/core/btlpm_req_if.sv
rtl/core/btlpm_rsp_if.sv
rtl/core/btlpm_dpath.sv
rtl/core/btlpm_ctrl.sv
rtl/core/binary_trie_longest_prefix_match_unit.sv
dv/binary_trie_longest_prefix_match_unit_tb.sv
